/* design/ssms_pkg.sv */
`default_nettype none

package ssms_pkg;

    // fixed field widths of the channels and of the item index
    localparam int PriceW = 32;
    localparam int SpanW  = 32;
    localparam int IndexW = 32;

    // item counter stops here
    localparam logic [IndexW-1:0] CountMax = {IndexW{1'b1}};

endpackage

`default_nettype wire

/* design/ssms_ifs.sv */
`default_nettype none

// price items into the block
interface ssms_in_if;
    import ssms_pkg::*;

    logic              valid;
    logic              ready;
    logic [PriceW-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

// span items out of the block
interface ssms_out_if;
    import ssms_pkg::*;

    logic             valid;
    logic             ready;
    logic [SpanW-1:0] span;
    logic             overflow;

    modport source (output valid, output span, output overflow, input ready);
    modport sink   (input valid, input span, input overflow, output ready);
endinterface

`default_nettype wire

/* design/ssms_stack_mem.sv */
`default_nettype none

module ssms_stack_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/ssms_ctrl.sv */
`default_nettype none

module ssms_ctrl #(
    parameter int STACK_DEPTH = 1024,
    parameter int STORE_W = 32,
    parameter int ADDR_W = 10,
    parameter int ENTRY_W = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ssms_in_if.sink                 price_ch,
    ssms_out_if.source              span_ch,
    output logic                    rd_en,
    output logic [ADDR_W-1:0]       rd_addr,
    input  wire logic [ENTRY_W-1:0] rd_data,
    output logic                    wr_en,
    output logic [ADDR_W-1:0]       wr_addr,
    output logic [ENTRY_W-1:0]      wr_data
);
    import ssms_pkg::*;

    localparam int FillW = $clog2(STACK_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(STACK_DEPTH - 1);
    localparam logic [FillW-1:0]  FullFill = FillW'(STACK_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CMP  = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [FillW-1:0]    fill_reg, fill_next;
    logic [ADDR_W-1:0]   tp_reg, tp_next;
    logic [IndexW-1:0]   count_reg, count_next;
    logic                overflow_reg, overflow_next;
    logic [STORE_W-1:0]  price_reg, price_next;
    logic [ENTRY_W-1:0]  top_reg, top_next;
    logic                top_fresh_reg, top_fresh_next;
    logic                out_valid_reg, out_valid_next;
    logic [SpanW-1:0]    span_reg, span_next;

    logic [ENTRY_W-1:0]  top_entry;
    logic [STORE_W-1:0]  top_price;
    logic [IndexW-1:0]   top_index;
    logic                pop;
    logic                out_free;
    logic                full;
    logic [ADDR_W-1:0]   tp_dec;
    logic [ADDR_W-1:0]   tp_dec2;
    logic [ADDR_W-1:0]   tp_inc;
    logic [IndexW-1:0]   span_raw;
    logic [SpanW-1:0]    span_val;

    // top of stack: freshly read from memory after a pop, else cached
    assign top_entry = top_fresh_reg ? rd_data : top_reg;
    assign top_price = top_entry[ENTRY_W-1 -: STORE_W];
    assign top_index = top_entry[IndexW-1:0];
    assign pop       = (fill_reg != '0) && (top_price <= price_reg);
    assign out_free  = !out_valid_reg || span_ch.ready;
    assign full      = (fill_reg == FullFill);

    // circular pointer arithmetic
    assign tp_dec  = (tp_reg == '0) ? LastAddr : tp_reg - 1'b1;
    assign tp_dec2 = (tp_dec == '0) ? LastAddr : tp_dec - 1'b1;
    assign tp_inc  = (tp_reg == LastAddr) ? '0 : tp_reg + 1'b1;

    // span against the entry left on top, at least one
    assign span_raw = (fill_reg == '0) ? count_reg : count_reg - top_index;
    assign span_val = (span_raw == '0) ? SpanW'(1) : SpanW'(span_raw);

    // handshakes
    assign price_ch.ready   = (state_reg == ST_IDLE);
    assign span_ch.valid    = out_valid_reg;
    assign span_ch.span     = span_reg;
    assign span_ch.overflow = overflow_reg;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        tp_next        = tp_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        price_next     = price_reg;
        top_next       = top_reg;
        top_fresh_next = top_fresh_reg;
        out_valid_next = out_valid_reg && !span_ch.ready;
        span_next      = span_reg;
        rd_en          = 1'b0;
        rd_addr        = tp_dec2;
        wr_en          = 1'b0;
        wr_addr        = tp_reg;
        wr_data        = {price_reg, count_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (price_ch.valid)
                begin
                    price_next = price_ch.price[STORE_W-1:0];
                    count_next = (count_reg == CountMax) ? count_reg : count_reg + 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (pop)
                begin
                    // drop the top, fetch the entry under it
                    fill_next      = fill_reg - 1'b1;
                    tp_next        = tp_dec;
                    rd_en          = (fill_reg != FillW'(1));
                    top_fresh_next = 1'b1;
                end
                else if (out_free)
                begin
                    // push, overwriting the oldest entry when full
                    wr_en          = 1'b1;
                    top_next       = {price_reg, count_reg};
                    top_fresh_next = 1'b0;
                    tp_next        = tp_inc;
                    fill_next      = full ? fill_reg : fill_reg + 1'b1;
                    overflow_next  = overflow_reg | full;
                    out_valid_next = 1'b1;
                    span_next      = span_val;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            tp_reg        <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            top_fresh_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            tp_reg        <= tp_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            top_fresh_reg <= top_fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        price_reg <= price_next;
        top_reg   <= top_next;
        span_reg  <= span_next;
    end

`ifndef SYNTHESIS
    // stack never holds more than its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FullFill)
        else $error("stack fill beyond depth");

    // a delivered span is never zero
    a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (span_reg != '0))
        else $error("zero span on output");

    // overflow flag is sticky
    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    // item counter never goes backwards
    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("item counter decreased");
`endif

endmodule

`default_nettype wire

/* design/stock_span_monotonic_stack.sv */
// Online stock span using a monotonic stack held in a synchronous memory.
//
// price_ch (sink): one price per item; only the low VALUE_WIDTH bits count.
// span_ch (source): one result per price item, carrying the span (number of
// consecutive items, ending with this one, priced at most this price) and a
// sticky overflow flag.
//
// An item is taken in the idle state. Then the stack entries priced at most
// its price are popped one at a time, and a last step pushes the item and
// loads the output register, waiting while that register is still full. Since
// each item pushes once, pops average at most one per item. The pop loop is
// bound by the registered read of the stack memory, hidden by a cached top entry.
//
// The stack is a circular buffer of STACK_DEPTH entries; a push onto a full
// stack overwrites the oldest entry and raises overflow until reset.
// Reset empties the stack, clears the item counter and the overflow flag;
// memory contents are not cleared and need no clearing pass.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and waits at its push until the output register frees.
`default_nettype none

module stock_span_monotonic_stack #(
    parameter int STACK_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ssms_in_if.sink    price_ch,
    ssms_out_if.source span_ch
);
    import ssms_pkg::*;

    localparam int StoreW = (VALUE_WIDTH < PriceW) ? VALUE_WIDTH : PriceW;
    localparam int AddrW  = $clog2(STACK_DEPTH);
    localparam int EntryW = StoreW + IndexW;

    logic              rd_en;
    logic [AddrW-1:0]  rd_addr;
    logic [EntryW-1:0] rd_data;
    logic              wr_en;
    logic [AddrW-1:0]  wr_addr;
    logic [EntryW-1:0] wr_data;

    // stack control
    ssms_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .STORE_W     (StoreW),
        .ADDR_W      (AddrW),
        .ENTRY_W     (EntryW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .price_ch (price_ch),
        .span_ch  (span_ch),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // stack storage, price and index per entry
    ssms_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .WIDTH  (EntryW),
        .ADDR_W (AddrW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_stock_span_monotonic_stack.sv */
`default_nettype none

module tb_stock_span_monotonic_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import ssms_pkg::*;

    localparam int StackDepth = 1024;
    localparam int ValueWidth = 32;
    localparam int QuietLimit = 20000;
    localparam int SettleCycles = 50;
    localparam int DescentLength = 700;
    localparam int MixedLength = 230;

    // flow-control phases
    typedef enum int {
        FLOW_FREE,
        FLOW_SENDER_IDLE,
        FLOW_RECEIVER_STALL,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct packed {
        logic [SpanW-1:0] span;
        logic             overflow;
    } span_item_t;

    logic clk;
    logic rst_n;

    ssms_in_if  price_if ();
    ssms_out_if span_if ();

    stock_span_monotonic_stack #(
        .STACK_DEPTH (StackDepth),
        .VALUE_WIDTH (ValueWidth)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .price_ch (price_if),
        .span_ch  (span_if)
    );

    // prices waiting to go out and spans waiting to come back
    logic [PriceW-1:0] prices_to_send[$];
    span_item_t        spans_due[$];

    // shadow of the price stack
    logic [PriceW-1:0] shadow_price[StackDepth];
    logic [IndexW-1:0] shadow_day[StackDepth];
    int                shadow_fill;
    logic [IndexW-1:0] day_count;
    logic              overflow_seen;
    int                deepest_fill;

    int         items_total;
    int         items_sent;
    int         prices_accepted;
    int         spans_checked;
    int         errors;
    int         quiet_cycles;
    logic       price_taken;
    span_item_t want;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // works out the span of one price and updates the shadow stack
    function automatic span_item_t next_span(logic [PriceW-1:0] price);
        span_item_t       res;
        logic [SpanW-1:0] span;
        if (day_count != CountMax)
            day_count++;
        while (shadow_fill > 0 && shadow_price[shadow_fill-1] <= price)
            shadow_fill--;
        if (shadow_fill == 0)
            span = day_count;
        else
            span = day_count - shadow_day[shadow_fill-1];
        if (span == 0)
            span = 1;
        // full stack drops its oldest entry
        if (shadow_fill >= StackDepth)
        begin
            for (int i = 0; i < StackDepth - 1; i++)
            begin
                shadow_price[i] = shadow_price[i+1];
                shadow_day[i]   = shadow_day[i+1];
            end
            shadow_fill   = StackDepth - 1;
            overflow_seen = 1'b1;
        end
        shadow_price[shadow_fill] = price;
        shadow_day[shadow_fill]   = day_count;
        shadow_fill++;
        if (shadow_fill > deepest_fill)
            deepest_fill = shadow_fill;
        res.span     = span;
        res.overflow = overflow_seen;
        return res;
    endfunction

    function automatic flow_mode_t current_mode();
        if (items_total == 0)
            return FLOW_FREE;
        return flow_mode_t'((items_sent * 4) / items_total);
    endfunction

    function automatic bit sender_idle();
        flow_mode_t m;
        m = current_mode();
        if (m == FLOW_SENDER_IDLE)
            return $urandom_range(99) < 77;
        if (m == FLOW_BOTH)
            return $urandom_range(99) < 28;
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        flow_mode_t m;
        m = current_mode();
        if (m == FLOW_RECEIVER_STALL)
            return $urandom_range(99) < 77;
        if (m == FLOW_BOTH)
            return $urandom_range(99) < 28;
        return 1'b0;
    endfunction

    // driver: new price after each accepted item, ready rolled every cycle
    always @(negedge clk)
    begin
        if (rst_n && (!price_if.valid || price_taken))
        begin
            if (prices_to_send.size() > 0 && !sender_idle())
            begin
                price_if.valid <= 1'b1;
                price_if.price <= prices_to_send.pop_front();
                items_sent++;
            end
            else
            begin
                price_if.valid <= 1'b0;
            end
        end
        span_if.ready <= rst_n && !receiver_stall();
    end

    // monitor: predict on each accepted price, check each accepted span
    always @(posedge clk)
    begin
        price_taken <= price_if.valid && price_if.ready;
        if (price_if.valid && price_if.ready)
        begin
            spans_due.push_back(next_span(price_if.price));
            prices_accepted++;
        end
        if (span_if.valid && span_if.ready)
        begin
            if (spans_due.size() == 0)
            begin
                $display("%0t: span item with none expected, got span %0d overflow %0b",
                         $time, span_if.span, span_if.overflow);
                errors++;
            end
            else
            begin
                want = spans_due.pop_front();
                spans_checked++;
                if (span_if.span !== want.span)
                begin
                    $display("%0t: span mismatch, expected %0d got %0d",
                             $time, want.span, span_if.span);
                    errors++;
                end
                if (span_if.overflow !== want.overflow)
                begin
                    $display("%0t: overflow mismatch, expected %0b got %0b",
                             $time, want.overflow, span_if.overflow);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((price_if.valid && price_if.ready) || (span_if.valid && span_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [PriceW-1:0] level;
        logic [PriceW-1:0] last;
        int                pick;

        price_if.valid  = 1'b0;
        price_if.price  = '0;
        span_if.ready   = 1'b0;
        price_taken     = 1'b0;
        shadow_fill     = 0;
        day_count       = '0;
        overflow_seen   = 1'b0;
        deepest_fill    = 0;
        items_total     = 0;
        items_sent      = 0;
        prices_accepted = 0;
        spans_checked   = 0;
        errors          = 0;
        quiet_cycles    = 0;
        rst_n           = 1'b0;

        // extremes, equal prices, rises, falls and a pop of everything
        prices_to_send = '{
            32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0005,
            32'h0000_0004, 32'h0000_0003, 32'h0000_0002, 32'h0000_0001,
            32'h0000_0003, 32'hFFFF_FFFE, 32'h0000_0000, 32'hFFFF_FFFF
        };

        // long strictly falling run that builds a deep stack
        level = 32'hF000_0000 | $urandom_range(32'h0FFF_FFFF);
        for (int i = 0; i < DescentLength; i++)
        begin
            level = level - $urandom_range(1, 32'h000F_FFFF);
            prices_to_send.push_back(level);
        end

        // mixed tail: noise, repeats, small moves and deep pops
        last = level;
        for (int i = 0; i < MixedLength; i++)
        begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2: last = $urandom;
                3:       last = last;
                4:       last = last + $urandom_range(1, 50);
                5:       last = last - $urandom_range(1, 50);
                6:       last = 32'hFFFF_FFFF;
                7:       last = 32'h0000_0000;
                default: last = $urandom_range(1000);
            endcase
            prices_to_send.push_back(last);
        end
        items_total = prices_to_send.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (prices_to_send.size() == 0 && prices_accepted == items_total);
        wait (spans_due.size() == 0);
        repeat (SettleCycles) @(posedge clk);

        if (spans_due.size() != 0)
        begin
            $display("%0t: %0d spans never arrived", $time, spans_due.size());
            errors++;
        end
        $display("%0d prices sent over four flow-control phases, %0d spans checked",
                 prices_accepted, spans_checked);
        $display("deepest stack %0d entries, stack overflow reached: %0b",
                 deepest_fill, overflow_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/ssms_pkg.sv
design/ssms_ifs.sv
design/ssms_stack_mem.sv
design/ssms_ctrl.sv
design/stock_span_monotonic_stack.sv
tb/sv/tb_stock_span_monotonic_stack.sv
